/* rtl/core/tdpg_pkg.sv */
// Package for the trial-division prime scanner: widths, command codes and
// the command/status structs between controller and datapath.
// No dependencies.
package tdpg_pkg;

    // Width of candidate, gap and count fields
    localparam int VALUE_WIDTH = 31;
    // Remainder bits resolved per cycle by the shift-subtract divider
    localparam int RADIX_BITS  = 4;
    localparam int DIV_STEPS   = (VALUE_WIDTH + RADIX_BITS - 1) / RADIX_BITS;
    localparam int SH_W        = DIV_STEPS * RADIX_BITS;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    // Divisor squared runs slightly past the candidate before the loop ends
    localparam int DSQ_W       = VALUE_WIDTH + 2;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted transaction
        logic div_start;  // set up remainder of candidate by current divisor
        logic div_step;   // resolve RADIX_BITS remainder bits
        logic next_div;   // move to the next odd divisor
        logic finish;     // update run state and load the result register
        logic verdict;    // candidate is prime (valid with finish)
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_start;   // captured transaction opens a run
        logic n_lt2;
        logic n_lt4;
        logic n_even;
        logic dsq_gt_n;   // divisor squared exceeds candidate
        logic div_last;   // last divider step in progress
        logic rem_zero;   // divisor divides candidate
    } t_dp_status;

endpackage

/* rtl/core/tdpg_if.sv */
// Channel interfaces of the prime scanner: input items and result items.
// Depends on tdpg_pkg.
interface tdpg_in_if import tdpg_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   cmd;
    t_value value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface tdpg_out_if import tdpg_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   is_prime;
    t_value gap;
    t_value prime_count;

    modport source (output valid, output is_prime, output gap, output prime_count,
                    input ready);
    modport sink   (input valid, input is_prime, input gap, input prime_count,
                    output ready);
endinterface

/* rtl/core/tdpg_dp.sv */
// Datapath of the prime scanner: candidate, divisor, divisor squared,
// radix-16 remainder unit, run state and result register.
// Depends on tdpg_pkg.
module tdpg_dp import tdpg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic       i_in_cmd,
    input  t_value     i_in_value,
    output t_dp_status o_status,
    output logic       o_is_prime,
    output t_value     o_gap,
    output t_value     o_prime_count
);

    logic              r_is_start;
    t_value            r_n;
    t_value            r_d;
    logic [DSQ_W-1:0]  r_dsq;
    t_value            r_rem;
    logic [SH_W-1:0]   r_sh;
    logic [CNT_W-1:0]  r_cnt;
    t_value            r_last_prime;
    t_value            r_found;
    logic              r_is_prime;
    t_value            r_gap;
    t_value            r_count_out;

    t_value            n_rem;
    t_value            n_found;

    // Shift-subtract remainder, RADIX_BITS dependent steps per cycle
    always_comb begin
        logic [VALUE_WIDTH:0] trial;
        n_rem = r_rem;
        for (int i = 0; i < RADIX_BITS; i++) begin
            trial = {n_rem, r_sh[SH_W-1-i]};
            if (trial >= {1'b0, r_d}) begin
                trial = trial - {1'b0, r_d};
            end
            n_rem = trial[VALUE_WIDTH-1:0];
        end
    end

    // Saturating prime count
    assign n_found = (r_found == '1) ? r_found : r_found + t_value'(1);

    // Candidate, divisor and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_start <= (i_in_cmd == CMD_START);
            r_n        <= i_in_value;
            r_d        <= t_value'(3);
            r_dsq      <= DSQ_W'(9);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_sh  <= SH_W'(r_n);
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_sh  <= r_sh << RADIX_BITS;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        // (d+2)^2 = d^2 + 4d + 4
        if (i_cmd.next_div) begin
            r_d   <= r_d + t_value'(2);
            r_dsq <= r_dsq + {r_d, 2'b00} + DSQ_W'(4);
        end
    end

    // Run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_prime <= '0;
            r_found      <= '0;
        end else if (i_cmd.finish) begin
            if (r_is_start) begin
                r_last_prime <= r_n;
                r_found      <= '0;
            end else if (i_cmd.verdict) begin
                r_last_prime <= r_n;
                r_found      <= n_found;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_is_start) begin
                r_is_prime  <= 1'b0;
                r_gap       <= '0;
                r_count_out <= '0;
            end else if (i_cmd.verdict) begin
                r_is_prime  <= 1'b1;
                r_gap       <= r_n - r_last_prime;
                r_count_out <= n_found;
            end else begin
                r_is_prime  <= 1'b0;
                r_gap       <= '0;
                r_count_out <= r_found;
            end
        end
    end

    assign o_status.is_start = r_is_start;
    assign o_status.n_lt2    = (r_n < t_value'(2));
    assign o_status.n_lt4    = (r_n < t_value'(4));
    assign o_status.n_even   = ~r_n[0];
    assign o_status.dsq_gt_n = (r_dsq > DSQ_W'(r_n));
    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_status.rem_zero = (r_rem == '0);

    assign o_is_prime    = r_is_prime;
    assign o_gap         = r_gap;
    assign o_prime_count = r_count_out;

endmodule

/* rtl/core/tdpg_ctrl.sv */
// Controller of the prime scanner: sequences the trial-division loop and
// owns the input ready and result valid.
// Depends on tdpg_pkg.
module tdpg_ctrl import tdpg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CLASSIFY = 6'b000010,
        S_TEST     = 6'b000100,
        S_DIV      = 6'b001000,
        S_CHECK    = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_prime, n_prime;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = ~r_out_valid | i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_prime     = r_prime;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.verdict = r_prime;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASSIFY;
                end
            end
            // start items, candidates below 4 and even candidates
            S_CLASSIFY: begin
                if (i_status.is_start || i_status.n_lt2) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else if (i_status.n_lt4) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else if (i_status.n_even) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.dsq_gt_n) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.rem_zero) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_TEST;
                end
            end
            // wait for the result register to drain
            S_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prime     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prime     <= n_prime;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/trial_division_prime_gap.sv */
// Top level of the trial-division prime scanner.
// Depends on tdpg_pkg, tdpg_if, tdpg_ctrl and tdpg_dp.
//
// One item at a time, one result per item. A start item (cmd 0), a candidate
// of 0..3 or an even one is decided in the classify state, and the input is
// ready again when its result is loaded into a free output register. An odd
// candidate runs odd divisors d = 3, 5, ... while d*d <= n, each a pass
// through the test, divide and check states with the radix-16 remainder
// unit, and a composite stops at its smallest odd factor. The next item
// is taken as soon as the controller is idle, while the last result still
// waits in the output register.
module trial_division_prime_gap import tdpg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdpg_in_if.sink    i_in,
    tdpg_out_if.source o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tdpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    tdpg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_cmd      (i_in.cmd),
        .i_in_value    (i_in.value),
        .o_status      (status),
        .o_is_prime    (o_out.is_prime),
        .o_gap         (o_out.gap),
        .o_prime_count (o_out.prime_count)
    );

endmodule

/* dv/trial_division_prime_gap_tb.sv */
// Self-checking testbench for the trial-division prime scanner: drives start and
// candidate transactions and checks prime flag, gap and running count.
// Depends on tdpg_pkg, tdpg_if and the trial_division_prime_gap RTL.
module trial_division_prime_gap_tb import tdpg_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Candidates at or above this are forced to a multiple of three so they stay cheap
    localparam t_value CHEAP_LIMIT   = t_value'(1 << 22);
    localparam int     RANDOM_ITEMS  = 76;
    // Cycles with no transaction on either side before the run is abandoned;
    // the slowest correct item is 2^31-1
    localparam int     IDLE_LIMIT    = 1_000_000;
    localparam int     DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic   is_prime;
        t_value gap;
        t_value prime_count;
    } t_scan_result;

    // Tracks the run state and holds the results still owed by the block
    class prime_gap_scoreboard;
        t_value       run_last_prime;
        t_value       run_count;
        t_scan_result owed_q[$];
        int           errors;
        int           checked;
        int           primes;
        int           starts;

        function new();
            run_last_prime = '0;
            run_count      = '0;
            errors         = 0;
            checked        = 0;
            primes         = 0;
            starts         = 0;
        endfunction

        // Odd divisors only; d*d is evaluated in 64 bits so it cannot overflow
        function bit test_prime(t_value n);
            longint unsigned d;
            if (n < 2) return 1'b0;
            if (n < 4) return 1'b1;
            if (!n[0]) return 1'b0;
            for (d = 3; d * d <= n; d += 2) begin
                if (n % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Accepted input transaction: update run state, queue the owed result
        function void note_input(logic c, t_value v);
            t_scan_result r;
            r = '0;
            if (c == CMD_START) begin
                run_last_prime = v;
                run_count      = '0;
                starts++;
            end else if (test_prime(v)) begin
                r.is_prime     = 1'b1;
                r.gap          = v - run_last_prime;   // wraps for falling candidates
                run_last_prime = v;
                if (run_count != '1) run_count++;
                primes++;
            end
            r.prime_count = run_count;
            owed_q.push_back(r);
        endfunction

        // Accepted result transaction against the oldest owed result
        function void check_result(t_scan_result got);
            t_scan_result want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result: prime=%0b gap=%0d count=%0d",
                             got.is_prime, got.gap, got.prime_count);
                return;
            end
            want = owed_q.pop_front();
            checked++;
            if (got != want) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d: prime %0b/%0b gap %0d/%0d count %0d/%0d",
                             checked, want.is_prime, got.is_prime, want.gap, got.gap,
                             want.prime_count, got.prime_count);
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tdpg_in_if  in_ch ();
    tdpg_out_if out_ch ();

    trial_division_prime_gap u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    prime_gap_scoreboard sb = new();
    int items_sent;
    int idle_cycles;

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Keep large candidates composite with a small factor
    function automatic t_value make_cheap(t_value v);
        if (v >= CHEAP_LIMIT) return v - (v % 3);
        return v;
    endfunction

    // Present one transaction and hold it until the block takes it
    task automatic send_item(input logic c, input t_value v, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= c;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(c, v);
        items_sent++;
    endtask

    // Edge cases: before any start, bound extremes, wrap-around gap, squares
    task automatic run_directed();
        send_item(CMD_TEST,  31'd0,          pick_gap(0));
        send_item(CMD_TEST,  31'd1,          pick_gap(0));
        send_item(CMD_TEST,  31'd2,          pick_gap(0));
        send_item(CMD_TEST,  31'd3,          pick_gap(0));
        send_item(CMD_TEST,  31'd4,          pick_gap(0));
        send_item(CMD_START, 31'd0,          pick_gap(0));
        send_item(CMD_TEST,  31'd5,          pick_gap(0));
        send_item(CMD_START, 31'h7FFF_FFFF,  pick_gap(0));
        send_item(CMD_TEST,  31'h7FFF_FFFF,  pick_gap(0));   // largest prime, gap 0
        send_item(CMD_TEST,  31'h7FFF_FFFE,  pick_gap(0));
        send_item(CMD_TEST,  31'd7,          pick_gap(0));   // falling prime, gap wraps
        send_item(CMD_START, 31'd100,        pick_gap(0));
        send_item(CMD_TEST,  31'd97,         pick_gap(0));   // prime below the bound
        send_item(CMD_TEST,  31'd101,        pick_gap(0));
        send_item(CMD_TEST,  31'd103,        pick_gap(0));
        send_item(CMD_TEST,  31'd9,          pick_gap(0));   // squares of primes
        send_item(CMD_TEST,  31'd49,         pick_gap(0));
        send_item(CMD_TEST,  31'd121,        pick_gap(0));
        send_item(CMD_TEST,  31'd65521,      pick_gap(0));
        send_item(CMD_TEST,  31'd65537,      pick_gap(0));
        send_item(CMD_TEST,  31'h4000_0000,  pick_gap(0));
        send_item(CMD_TEST,  31'h7FFF_FFFD,  pick_gap(0));   // multiple of five
        send_item(CMD_TEST,  31'd1,          pick_gap(0));
        send_item(CMD_TEST,  31'd0,          pick_gap(0));
    endtask

    // One run: usually a start then rising candidates, sometimes noise or a
    // run that skips the start or steps backwards
    task automatic run_random_sequence(ref int count);
        t_value bound;
        t_value cand;
        int     kind;
        int     len;
        int     r;
        bit     calm;
        calm = ($urandom_range(3) == 0);
        kind = $urandom_range(99);
        if (kind < 10) begin
            len = $urandom_range(4, 1);
            repeat (len) begin
                cand = ($urandom_range(1) == 0) ? t_value'($urandom) :
                                                  t_value'($urandom_range(300));
                send_item(($urandom_range(9) < 3) ? CMD_START : CMD_TEST,
                          make_cheap(cand), pick_gap(calm));
                count++;
            end
            return;
        end
        r = $urandom_range(99);
        if (r < 50)      bound = t_value'($urandom_range(2000));
        else if (r < 80) bound = t_value'($urandom_range(CHEAP_LIMIT, 2000));
        else             bound = t_value'($urandom);
        if (kind >= 20) begin
            send_item(CMD_START, bound, pick_gap(calm));
            count++;
        end
        cand = bound;
        len  = $urandom_range(10, 3);
        repeat (len) begin
            if (kind < 30 && $urandom_range(3) == 0)
                cand = cand - t_value'($urandom_range(60, 1));
            else
                cand = cand + t_value'($urandom_range(30, 1));
            send_item(CMD_TEST, make_cheap(cand), pick_gap(calm));
            count++;
        end
    endtask

    // Stimulus and end of run
    initial begin
        int random_count;
        random_count = 0;
        items_sent   = 0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= CMD_START;
        in_ch.value <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        while (random_count < RANDOM_ITEMS) run_random_sequence(random_count);
        in_ch.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.outstanding() != 0) sb.errors++;
        $display("Sent %0d transactions (%0d run starts); checked %0d results, %0d primes.",
                 items_sent, sb.starts, sb.checked, sb.primes);
        $display("Errors: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("trial_division_prime_gap: match");
        end else begin
            $display("trial_division_prime_gap: mismatch");
        end
        $finish;
    end

    // Result side back-pressure: short bursts of ready, occasional long runs
    initial begin
        int run_len;
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            out_ch.ready <= 1'b1;
            run_len = ($urandom_range(9) == 0) ? $urandom_range(400, 100) :
                                                 $urandom_range(8, 1);
            repeat (run_len) @(posedge i_clk);
            stall = pick_gap(0);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.is_prime, out_ch.gap, out_ch.prime_count});
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("trial_division_prime_gap: mismatch");
                $finish;
            end
        end
    end

endmodule
